### sv/keyboard_matrix_emulator_core_assert.svh
// Assertion macros for the keyboard matrix emulator core.
// Each macro expects signals named clock and reset in the including scope.
`ifndef KEYBOARD_MATRIX_EMULATOR_CORE_ASSERT_SVH
`define KEYBOARD_MATRIX_EMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KME_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/kme_pkg.sv
// Shared types and constants of the keyboard matrix emulator.
// No dependencies.
package kme_pkg;

   localparam int ROW_COUNT     = 16;
   localparam int ROW_BITS      = 4;
   localparam int KEY_COUNT     = 6;
   localparam int KEY_IDX_BITS  = 3;
   localparam int TABLE_ENTRIES = 256;
   localparam int ENTRY_BITS    = 12;

   localparam logic [ROW_BITS-1:0] ANY_ROW  = 4'd15;
   localparam logic [ROW_BITS-1:0] MOD_ROW  = 4'd11;
   localparam logic [ROW_BITS-1:0] ANY_LAST = 4'd13;

   localparam logic [7:0] ROW_IDLE   = 8'hFF;
   localparam logic [7:0] MOD_SHIFT  = 8'h22;
   localparam logic [7:0] MOD_CTRL   = 8'h11;
   localparam logic [7:0] MOD_ALT    = 8'h44;
   localparam logic [7:0] CLR_SHIFT  = 8'hFB;
   localparam logic [7:0] CLR_CTRL   = 8'hEF;
   localparam logic [7:0] CLR_ALT    = 8'hFE;

   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_UPPER = 2'd1;
   localparam logic [1:0] PHASE_LOWER = 2'd2;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_BUS    = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEYS,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

### sv/keyboard_matrix_emulator_core.sv
// Keyboard matrix emulator core: report translation, key matrix and nibble bus.
// Depends on kme_pkg, kme_ram and keyboard_matrix_emulator_core_assert.svh.
//
// Each accepted item yields exactly one result item holding the bus status
// (drive enable, driven nibble, bus phase). One item is handled at a time and
// req_stall stays high until its result has been taken. A table load or a bus
// sample reaches the result register in the cycle after acceptance. A keyboard
// report sets the modifier row on acceptance, then runs the six key codes
// through the single read port of the 256-entry translation RAM (one lookup
// issued per cycle, each applied in the next cycle by the one row-clear unit),
// and finally writes the any-key row. The any-key row is accumulated alongside
// the row clears, so no separate pass over the matrix is needed. Codes whose
// table entry was never loaded read back whatever the RAM holds; keep them out
// of reports.
module keyboard_matrix_emulator_core (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic [7:0]                   req_modifier_bits,
   input  logic [7:0]                   req_key_code_0,
   input  logic [7:0]                   req_key_code_1,
   input  logic [7:0]                   req_key_code_2,
   input  logic [7:0]                   req_key_code_3,
   input  logic [7:0]                   req_key_code_4,
   input  logic [7:0]                   req_key_code_5,
   input  logic [7:0]                   req_entry_code,
   input  logic [7:0]                   req_entry_mask,
   input  logic [kme_pkg::ROW_BITS-1:0] req_entry_row,
   input  logic [6:0]                   req_bus_pins,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_drive_enable,
   output logic [3:0]                   rsp_drive_nibble,
   output logic [1:0]                   rsp_bus_phase
);
   import kme_pkg::*;

   // sequencer and matrix state
   state_type                state_ff, state_in;
   logic [7:0]               rows_ff [ROW_COUNT];
   logic [7:0]               rows_in [ROW_COUNT];
   logic [7:0]               any_ff, any_in;
   logic [7:0]               keys_ff [KEY_COUNT];
   logic [7:0]               keys_in [KEY_COUNT];
   logic [KEY_IDX_BITS-1:0]  idx_ff, idx_in;
   logic                     pend_ff, pend_in;

   // bus state
   logic [ROW_BITS-1:0]      sel_ff, sel_in;
   logic [1:0]               phase_ff, phase_in;
   logic                     driven_ff, driven_in;
   logic [3:0]               value_ff, value_in;

   // translation RAM port
   logic                     ram_we;
   logic [7:0]               ram_raddr;
   logic [ENTRY_BITS-1:0]    ram_rdata;

   // working signals
   logic                     req_accept;
   logic [7:0]               mod_row;
   logic [7:0]               ent_mask;
   logic [ROW_BITS-1:0]      ent_row;
   logic [7:0]               bus_src;
   logic                     idx_live;
   logic [7:0]               rows_and;

   kme_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_entry_code),
      .wr_data ({req_entry_row, req_entry_mask}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Result fields come straight from the bus registers, which hold while
   // the result waits.
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_drive_enable = driven_ff;
   assign rsp_drive_nibble = driven_ff ? value_ff : 4'd0;
   assign rsp_bus_phase    = phase_ff;

   // Modifier row: shift, ctrl and alt each clear one bit of row 11.
   always_comb begin
      mod_row = ROW_IDLE;
      if ((req_modifier_bits & MOD_SHIFT) != 8'd0) mod_row = mod_row & CLR_SHIFT;
      if ((req_modifier_bits & MOD_CTRL) != 8'd0)  mod_row = mod_row & CLR_CTRL;
      if ((req_modifier_bits & MOD_ALT) != 8'd0)   mod_row = mod_row & CLR_ALT;
   end

   assign ent_mask  = ram_rdata[7:0];
   assign ent_row   = ram_rdata[ENTRY_BITS-1:8];
   assign idx_live  = (idx_ff < KEY_IDX_BITS'(KEY_COUNT));
   assign ram_raddr = idx_live ? keys_ff[idx_ff] : 8'd0;
   assign bus_src   = req_bus_pins[5] ? rows_ff[sel_ff] : rows_ff[ANY_ROW];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      any_in    = any_ff;
      keys_in   = keys_ff;
      idx_in    = idx_ff;
      pend_in   = 1'b0;
      sel_in    = sel_ff;
      phase_in  = phase_ff;
      driven_in = driven_ff;
      value_in  = value_ff;
      ram_we    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (kind_type'(req_kind))
                  KIND_LOAD: begin
                     ram_we   = 1'b1;
                     state_in = ST_RESP;
                  end
                  KIND_REPORT: begin
                     // clear the matrix, set the modifier row, latch the codes
                     for (int r = 0; r < ROW_COUNT; r++) begin
                        rows_in[r] = ROW_IDLE;
                     end
                     rows_in[MOD_ROW] = mod_row;
                     any_in     = mod_row;
                     keys_in[0] = req_key_code_0;
                     keys_in[1] = req_key_code_1;
                     keys_in[2] = req_key_code_2;
                     keys_in[3] = req_key_code_3;
                     keys_in[4] = req_key_code_4;
                     keys_in[5] = req_key_code_5;
                     idx_in     = '0;
                     state_in   = ST_KEYS;
                  end
                  KIND_BUS: begin
                     if (req_bus_pins[0]) begin
                        // strobe: latch the row, release the pins
                        driven_in = 1'b0;
                        sel_in    = req_bus_pins[4:1];
                        phase_in  = PHASE_IDLE;
                     end else begin
                        driven_in = 1'b1;
                        if (req_bus_pins[6] && phase_ff == PHASE_IDLE) begin
                           value_in = bus_src[7:4];
                           phase_in = PHASE_UPPER;
                        end else if (!req_bus_pins[6] && phase_ff == PHASE_UPPER) begin
                           value_in = bus_src[3:0];
                           phase_in = PHASE_LOWER;
                        end
                     end
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_KEYS: begin
            // apply the lookup issued last cycle
            if (pend_ff && ent_mask != 8'd0) begin
               rows_in[ent_row] = rows_ff[ent_row] & ~ent_mask;
               if (ent_row <= ANY_LAST) begin
                  any_in = any_ff & ~ent_mask;
               end
            end
            // issue the next lookup
            if (idx_live) begin
               pend_in = (keys_ff[idx_ff] != 8'd0);
               idx_in  = idx_ff + KEY_IDX_BITS'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rows_in[ANY_ROW] = any_ff;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            rows_ff[r] <= ROW_IDLE;
         end
         any_ff    <= ROW_IDLE;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         sel_ff    <= '0;
         phase_ff  <= PHASE_IDLE;
         driven_ff <= 1'b0;
         value_ff  <= 4'd0;
      end else begin
         rows_ff   <= rows_in;
         any_ff    <= any_in;
         idx_ff    <= idx_in;
         pend_ff   <= pend_in;
         sel_ff    <= sel_in;
         phase_ff  <= phase_in;
         driven_ff <= driven_in;
         value_ff  <= value_in;
      end
   end

   // key codes are payload: no reset
   always_ff @(posedge clock) begin
      keys_ff <= keys_in;
   end

   // Reference AND of rows 0 to 13, used to check the accumulated any-key row.
   always_comb begin
      rows_and = ROW_IDLE;
      for (int r = 0; r <= int'(ANY_LAST); r++) begin
         rows_and = rows_and & rows_ff[r];
      end
   end

`include "keyboard_matrix_emulator_core_assert.svh"

   `KME_ASSERT_NEXT(a_any_row, state_ff == ST_FINISH,
      rows_ff[ANY_ROW] == rows_and,
      "any-key row does not match rows 0 to 13")
   `KME_ASSERT_NEXT(a_strobe_release,
      req_accept && req_kind == KIND_BUS && req_bus_pins[0],
      !driven_ff && phase_ff == PHASE_IDLE && sel_ff == $past(req_bus_pins[4:1]),
      "strobe did not release the bus")
   `KME_ASSERT_IMPLY(a_idx_bound, state_ff == ST_KEYS,
      idx_ff <= KEY_IDX_BITS'(KEY_COUNT),
      "key index ran past the report")
   `KME_ASSERT_IMPLY(a_busy_while_rsp, rsp_valid, req_stall,
      "request taken while a result waits")

endmodule

### sv/kme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
